### rtl/efd_pkg.sv
//------------------------------------------------------------------------------
// efd_pkg
// Shared constants, types and helpers of the escaped frame deframer.
//------------------------------------------------------------------------------
`default_nettype none

package efd_pkg;

    // payload store depth and its address width
    localparam int MAX_PAYLOAD = 64;
    localparam int PAYLOAD_AW  = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    // field widths fixed by the frame format
    localparam int BYTE_W = 8;
    localparam int CMD_W  = 16;
    localparam int LEN_W  = 7;

    localparam logic [LEN_W-1:0] MAX_PAYLOAD_LEN = LEN_W'(MAX_PAYLOAD);
    localparam logic [LEN_W-1:0] MAX_LENGTH_RST  = 7'd64;

    // special bytes of the link
    localparam logic [BYTE_W-1:0] HEAD_BYTE = 8'hAA;
    localparam logic [BYTE_W-1:0] ESC_BYTE  = 8'hAB;
    localparam logic [BYTE_W-1:0] ESC_HEAD  = 8'h01;
    localparam logic [BYTE_W-1:0] ESC_ESC   = 8'h02;

    // commands from the controller to the datapath
    typedef struct packed {
        logic take;        // byte accepted, remember it as previous byte
        logic head;        // head byte, restart checksum and store pointer
        logic body;        // unescaped body byte, fold into checksum
        logic ld_cmd_hi;
        logic ld_cmd_lo;
        logic ld_len_hi;
        logic ld_len_lo;
        logic wr_payload;  // write payload byte to the store
        logic start_run;   // rewind the read pointer for the output run
        logic load_out;    // load one result into the output register
    } t_dp_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic rx_head;
        logic rx_esc;
        logic len_bad;     // length above the effective limit
        logic len_zero;
        logic rem_one;     // current payload byte is the final one
        logic xor_ok;      // checksum ends at zero with this byte
        logic out_free;    // output register can take a result
        logic run_last;    // next result closes the run
    } t_dp_status;

    // resolve an escape pair
    function automatic logic [BYTE_W-1:0] unescape(
        input logic [BYTE_W-1:0] prev,
        input logic [BYTE_W-1:0] now
    );
        logic [BYTE_W-1:0] v;
        v = now;
        if (prev == ESC_BYTE && now == ESC_HEAD) begin
            v = HEAD_BYTE;
        end else if (prev == ESC_BYTE && now == ESC_ESC) begin
            v = ESC_BYTE;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

### rtl/efd_ifs.sv
//------------------------------------------------------------------------------
// efd_ifs
// Valid/ready channels of the escaped frame deframer.
//------------------------------------------------------------------------------
`default_nettype none

// received byte channel
interface efd_in_if import efd_pkg::*;;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// frame result channel
interface efd_out_if import efd_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [LEN_W-1:0]  payload_length;
    logic [BYTE_W-1:0] data_byte;
    logic              data_valid;
    logic              last;

    modport source (output valid, output command, output payload_length,
                    output data_byte, output data_valid, output last, input ready);
    modport sink   (input valid, input command, input payload_length,
                    input data_byte, input data_valid, input last, output ready);
endinterface

// configuration write channel
interface efd_cfg_if import efd_pkg::*;;
    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] max_length;

    modport source (output valid, output max_length, input ready);
    modport sink   (input valid, input max_length, output ready);
endinterface

`default_nettype wire

### rtl/efd_ctrl.sv
//------------------------------------------------------------------------------
// efd_ctrl
// Parser and run controller: walks the frame fields and drives the datapath.
//------------------------------------------------------------------------------
`default_nettype none

module efd_ctrl import efd_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_rx_valid,
    output logic       o_rx_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMD_HI,
        S_CMD_LO,
        S_LEN_HI,
        S_LEN_LO,
        S_PAYLOAD,
        S_CHECK,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   rx_fire;

    // no bytes are taken while a run is read out of the store
    assign o_rx_ready = (r_state != S_EMIT);
    assign rx_fire    = i_rx_valid && o_rx_ready;

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        if (r_state == S_EMIT) begin
            if (i_status.out_free) begin
                o_cmd.load_out = 1'b1;
                if (i_status.run_last) begin
                    n_state = S_IDLE;
                end
            end
        end else if (rx_fire) begin
            o_cmd.take = 1'b1;
            if (i_status.rx_head) begin
                o_cmd.head = 1'b1;
                n_state    = S_CMD_HI;
            end else if (r_state != S_IDLE && !i_status.rx_esc) begin
                o_cmd.body = 1'b1;
                unique case (r_state)
                    S_CMD_HI: begin
                        o_cmd.ld_cmd_hi = 1'b1;
                        n_state         = S_CMD_LO;
                    end
                    S_CMD_LO: begin
                        o_cmd.ld_cmd_lo = 1'b1;
                        n_state         = S_LEN_HI;
                    end
                    S_LEN_HI: begin
                        o_cmd.ld_len_hi = 1'b1;
                        n_state         = S_LEN_LO;
                    end
                    S_LEN_LO: begin
                        o_cmd.ld_len_lo = 1'b1;
                        priority if (i_status.len_bad) begin
                            n_state = S_IDLE;
                        end else if (i_status.len_zero) begin
                            n_state = S_CHECK;
                        end else begin
                            n_state = S_PAYLOAD;
                        end
                    end
                    S_PAYLOAD: begin
                        o_cmd.wr_payload = 1'b1;
                        if (i_status.rem_one) begin
                            n_state = S_CHECK;
                        end
                    end
                    S_CHECK: begin
                        if (i_status.xor_ok) begin
                            o_cmd.start_run = 1'b1;
                            n_state         = S_EMIT;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

### rtl/efd_dp.sv
//------------------------------------------------------------------------------
// efd_dp
// Datapath: unescape, checksum, header fields, payload store, output register.
//------------------------------------------------------------------------------
`default_nettype none

module efd_dp import efd_pkg::*; (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire  [BYTE_W-1:0] i_rx_byte,
    input  wire               i_cfg_valid,
    input  wire  [LEN_W-1:0]  i_cfg_max_length,
    input  t_dp_cmd           i_cmd,
    output t_dp_status        o_status,
    input  wire               i_out_ready,
    output logic              o_out_valid,
    output logic [CMD_W-1:0]  o_command,
    output logic [LEN_W-1:0]  o_payload_length,
    output logic [BYTE_W-1:0] o_data_byte,
    output logic              o_data_valid,
    output logic              o_last
);

    logic [BYTE_W-1:0] r_prev;
    logic [BYTE_W-1:0] r_xor;
    logic [CMD_W-1:0]  r_cmd;
    logic [BYTE_W-1:0] r_len_hi;
    logic [LEN_W-1:0]  r_len;
    logic [LEN_W-1:0]  r_rem;
    logic [LEN_W-1:0]  r_widx;
    logic [LEN_W-1:0]  r_ridx;
    logic [LEN_W-1:0]  r_max_len;
    logic [BYTE_W-1:0] r_mem [MAX_PAYLOAD];

    logic              r_out_valid;
    logic [CMD_W-1:0]  r_out_cmd;
    logic [LEN_W-1:0]  r_out_len;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_dv;
    logic              r_out_last;

    logic [BYTE_W-1:0] v;
    logic [LEN_W-1:0]  limit;
    logic [15:0]       len_full;

    // unescaped byte and length checks
    assign v        = unescape(r_prev, i_rx_byte);
    assign limit    = (r_max_len > MAX_PAYLOAD_LEN) ? MAX_PAYLOAD_LEN : r_max_len;
    assign len_full = {r_len_hi, v};

    assign o_status.rx_head  = (i_rx_byte == HEAD_BYTE);
    assign o_status.rx_esc   = (i_rx_byte == ESC_BYTE);
    assign o_status.len_bad  = (len_full > {9'd0, limit});
    assign o_status.len_zero = (len_full == 16'd0);
    assign o_status.rem_one  = (r_rem == LEN_W'(1));
    assign o_status.xor_ok   = ((r_xor ^ v) == '0);
    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_status.run_last = (r_len == '0) || (r_ridx == r_len - LEN_W'(1));

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LENGTH_RST;
        end else if (i_cfg_valid) begin
            r_max_len <= i_cfg_max_length;
        end
    end

    // parser registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev   <= '0;
            r_xor    <= '0;
            r_cmd    <= '0;
            r_len_hi <= '0;
            r_len    <= '0;
            r_rem    <= '0;
            r_widx   <= '0;
            r_ridx   <= '0;
        end else begin
            if (i_cmd.take) begin
                r_prev <= i_rx_byte;
            end
            if (i_cmd.head) begin
                r_xor  <= HEAD_BYTE;
                r_widx <= '0;
            end
            if (i_cmd.body) begin
                r_xor <= r_xor ^ v;
            end
            if (i_cmd.ld_cmd_hi) begin
                r_cmd[15:8] <= v;
            end
            if (i_cmd.ld_cmd_lo) begin
                r_cmd[7:0] <= v;
            end
            if (i_cmd.ld_len_hi) begin
                r_len_hi <= v;
            end
            // an accepted length fits in the low bits of its low byte
            if (i_cmd.ld_len_lo) begin
                r_len <= v[LEN_W-1:0];
                r_rem <= v[LEN_W-1:0];
            end
            if (i_cmd.wr_payload) begin
                r_widx <= r_widx + LEN_W'(1);
                r_rem  <= r_rem - LEN_W'(1);
            end
            if (i_cmd.start_run) begin
                r_ridx <= '0;
            end else if (i_cmd.load_out) begin
                r_ridx <= r_ridx + LEN_W'(1);
            end
        end
    end

    // payload store
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_payload) begin
            r_mem[r_widx[PAYLOAD_AW-1:0]] <= v;
        end
    end

    // output register, read port of the store feeds it directly
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_cmd  <= r_cmd;
            r_out_len  <= r_len;
            r_out_byte <= r_mem[r_ridx[PAYLOAD_AW-1:0]];
            r_out_dv   <= (r_len != '0);
            r_out_last <= o_status.run_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_command        = r_out_cmd;
    assign o_payload_length = r_out_len;
    assign o_data_byte      = r_out_dv ? r_out_byte : '0;
    assign o_data_valid     = r_out_dv;
    assign o_last           = r_out_last;

endmodule

`default_nettype wire

### rtl/escaped_frame_deframer.sv
//------------------------------------------------------------------------------
// escaped_frame_deframer
// Recovers byte-stuffed frames with an XOR check from a received byte stream.
//------------------------------------------------------------------------------
// Usage:
//   i_rx    : received bytes, one per transaction. A frame is head 0xAA, then
//             escaped command (2 bytes), length (2 bytes), payload and check.
//   o_frame : one result per payload byte of a frame whose check passes, or a
//             single result with data_valid low for an empty frame; last marks
//             the end of the run. Frames that fail are dropped silently.
//   i_cfg   : writes max_length; always ready, write only while idle.
// Timing:
//   the check byte of a good frame starts a run that loads one result per cycle
//   from the payload store into the output register, paused while the output
//   register holds a result that is not taken.
//   i_rx is not ready during the run; it is ready again once the final result
//   sits in the output register, even if that result is not yet taken.
// Reset:
//   synchronous, active low; parser idle, max_length 64, output empty.
// Stall:
//   a stalled output holds its result and pauses the run.
//------------------------------------------------------------------------------
`default_nettype none

module escaped_frame_deframer import efd_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    efd_in_if.sink     i_rx,
    efd_out_if.source  o_frame,
    efd_cfg_if.sink    i_cfg
);

    t_dp_cmd    cmd;
    t_dp_status status;

    assign i_cfg.ready = 1'b1;

    // parser and run control
    efd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx.valid),
        .o_rx_ready (i_rx.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // fields, store and output register
    efd_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_rx_byte        (i_rx.rx_byte),
        .i_cfg_valid      (i_cfg.valid),
        .i_cfg_max_length (i_cfg.max_length),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_out_ready      (o_frame.ready),
        .o_out_valid      (o_frame.valid),
        .o_command        (o_frame.command),
        .o_payload_length (o_frame.payload_length),
        .o_data_byte      (o_frame.data_byte),
        .o_data_valid     (o_frame.data_valid),
        .o_last           (o_frame.last)
    );

endmodule

`default_nettype wire

### rtl/efd_checker.sv
//------------------------------------------------------------------------------
// efd_checker
// Port-level checks of the escaped frame deframer, bound to the top level.
//------------------------------------------------------------------------------
`default_nettype none

module efd_checker import efd_pkg::*; (
    input wire              i_clk,
    input wire              i_rst_n,
    input wire              i_rx_ready,
    input wire              i_out_valid,
    input wire              i_out_ready,
    input wire [CMD_W-1:0]  i_command,
    input wire [LEN_W-1:0]  i_payload_length,
    input wire [BYTE_W-1:0] i_data_byte,
    input wire              i_data_valid,
    input wire              i_last
);

    // a stalled result stays and holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_command)
            && $stable(i_payload_length) && $stable(i_data_byte)
            && $stable(i_data_valid) && $stable(i_last))
        else $error("stalled result changed");

    // an empty frame gives exactly one closing result
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_data_valid |-> i_last && i_payload_length == '0
            && i_data_byte == '0)
        else $error("empty frame result malformed");

    // payload results carry a length within the store
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_data_valid |-> i_payload_length != '0
            && i_payload_length <= MAX_PAYLOAD_LEN)
        else $error("payload length out of range");

    // input waits while a run is still being delivered
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_last |-> !i_rx_ready)
        else $error("byte taken during an output run");

endmodule

bind escaped_frame_deframer efd_checker u_efd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_rx_ready       (i_rx.ready),
    .i_out_valid      (o_frame.valid),
    .i_out_ready      (o_frame.ready),
    .i_command        (o_frame.command),
    .i_payload_length (o_frame.payload_length),
    .i_data_byte      (o_frame.data_byte),
    .i_data_valid     (o_frame.data_valid),
    .i_last           (o_frame.last)
);

`default_nettype wire

### tb/escaped_frame_deframer_test.sv
//------------------------------------------------------------------------------
// escaped_frame_deframer_test
// Self-checking bench for the escaped frame deframer. Sends byte-stuffed frames
// and link noise on the byte channel, with idle and stall bursts on both sides,
// under several max_length settings. A scoreboard follows the parser byte by
// byte and checks each frame result in order.
//------------------------------------------------------------------------------
import efd_pkg::*;

// one result of a frame run
typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [LEN_W-1:0]  payload_length;
    logic [BYTE_W-1:0] data_byte;
    logic              data_valid;
    logic              last;
} frame_result_t;

// parser stages of the deframer
typedef enum logic [2:0] {
    PH_IDLE,
    PH_CMD_HI,
    PH_CMD_LO,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_PAYLOAD,
    PH_CHECK
} parse_phase_t;

// tracks the parser state and holds the frame results still to come
class frame_scoreboard;
    parse_phase_t      phase;
    logic [BYTE_W-1:0] prev_byte;
    logic [15:0]       cmd_word;
    logic [15:0]       len_word;
    logic [15:0]       bytes_left;
    logic [BYTE_W-1:0] xor_sum;
    logic [BYTE_W-1:0] payload_mem [MAX_PAYLOAD];
    logic [LEN_W-1:0]  wr_ptr;
    logic [LEN_W-1:0]  max_len;
    frame_result_t     pending_results[$];
    int                mismatches;
    int                results_seen;
    int                good_frames;

    function new();
        phase        = PH_IDLE;
        prev_byte    = '0;
        cmd_word     = '0;
        len_word     = '0;
        bytes_left   = '0;
        xor_sum      = '0;
        wr_ptr       = '0;
        max_len      = MAX_LENGTH_RST;
        mismatches   = 0;
        results_seen = 0;
        good_frames  = 0;
        foreach (payload_mem[i]) payload_mem[i] = '0;
    endfunction

    function void set_max_length(input logic [LEN_W-1:0] v);
        max_len = v;
    endfunction

    function int pending();
        return pending_results.size();
    endfunction

    // one received byte transaction
    function void note_byte(input logic [BYTE_W-1:0] rx);
        logic [BYTE_W-1:0] v;
        int                limit;
        frame_result_t     r;

        // head byte restarts the frame wherever the parser is
        if (rx == HEAD_BYTE) begin
            xor_sum   = HEAD_BYTE;
            prev_byte = rx;
            wr_ptr    = '0;
            phase     = PH_CMD_HI;
            return;
        end
        // escape byte inside a frame only marks the next byte
        if (phase != PH_IDLE && rx == ESC_BYTE) begin
            prev_byte = rx;
            return;
        end

        v = rx;
        if (prev_byte == ESC_BYTE && rx == ESC_HEAD) v = HEAD_BYTE;
        if (prev_byte == ESC_BYTE && rx == ESC_ESC) v = ESC_BYTE;

        case (phase)
            PH_CMD_HI: begin
                xor_sum ^= v;
                cmd_word[15:8] = v;
                phase = PH_CMD_LO;
            end
            PH_CMD_LO: begin
                xor_sum ^= v;
                cmd_word[7:0] = v;
                phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                xor_sum ^= v;
                len_word[15:8] = v;
                phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                xor_sum ^= v;
                len_word[7:0] = v;
                limit = (int'(max_len) > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(max_len);
                bytes_left = len_word;
                if (int'(len_word) > limit) begin
                    phase = PH_IDLE;
                end else if (len_word == 0) begin
                    phase = PH_CHECK;
                end else begin
                    phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                xor_sum ^= v;
                if (int'(wr_ptr) < MAX_PAYLOAD) payload_mem[wr_ptr] = v;
                wr_ptr = wr_ptr + 1'b1;
                bytes_left = bytes_left - 1'b1;
                if (bytes_left == 0) phase = PH_CHECK;
            end
            PH_CHECK: begin
                xor_sum ^= v;
                // good check: queue the whole run of the frame
                if (xor_sum == 0) begin
                    good_frames++;
                    r.command = cmd_word;
                    if (len_word == 0) begin
                        r.payload_length = '0;
                        r.data_byte      = '0;
                        r.data_valid     = 1'b0;
                        r.last           = 1'b1;
                        pending_results.push_back(r);
                    end else begin
                        for (int i = 0; i < int'(len_word) && i < MAX_PAYLOAD; i++) begin
                            r.payload_length = len_word[LEN_W-1:0];
                            r.data_byte      = payload_mem[i];
                            r.data_valid     = 1'b1;
                            r.last           = (i + 1 == int'(len_word));
                            pending_results.push_back(r);
                        end
                    end
                end
                phase = PH_IDLE;
            end
            default: begin
                phase = PH_IDLE;
            end
        endcase
        prev_byte = rx;
    endfunction

    // one frame result transaction
    function void check_result(input frame_result_t got);
        frame_result_t want;

        results_seen++;
        if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("%t unexpected result: cmd %h len %0d data %h dv %b last %b",
                         $realtime, got.command, got.payload_length, got.data_byte,
                         got.data_valid, got.last);
            end
            return;
        end
        want = pending_results.pop_front();
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("%t result mismatch", $realtime);
                $display("  expected: cmd %h len %0d data %h dv %b last %b",
                         want.command, want.payload_length, want.data_byte,
                         want.data_valid, want.last);
                $display("  actual:   cmd %h len %0d data %h dv %b last %b",
                         got.command, got.payload_length, got.data_byte,
                         got.data_valid, got.last);
            end
        end
    endfunction
endclass

module escaped_frame_deframer_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES = 300;

    logic i_clk;
    logic i_rst_n;

    efd_in_if  rx_ch();
    efd_out_if frame_ch();
    efd_cfg_if cfg_ch();

    escaped_frame_deframer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_ch),
        .o_frame (frame_ch),
        .i_cfg   (cfg_ch)
    );

    frame_scoreboard   sb;
    logic [BYTE_W-1:0] link_bytes[$];
    bit                idle_en;
    bit                hold_req;
    int                cur_limit;
    int                frame_bytes;
    int                total_bytes;
    int                settings_used;

    // clock
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // run limit
    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // sample accepted transactions on every channel
    always @(posedge i_clk) begin : monitor
        frame_result_t got;
        if (i_rst_n) begin
            if (frame_ch.valid && frame_ch.ready) begin
                got.command        = frame_ch.command;
                got.payload_length = frame_ch.payload_length;
                got.data_byte      = frame_ch.data_byte;
                got.data_valid     = frame_ch.data_valid;
                got.last           = frame_ch.last;
                sb.check_result(got);
            end
            if (rx_ch.valid && rx_ch.ready) sb.note_byte(rx_ch.rx_byte);
            if (cfg_ch.valid && cfg_ch.ready) sb.set_max_length(cfg_ch.max_length);
        end
    end

    // result receiver: ready bursts, stall bursts and one long hold-off
    initial begin
        frame_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                frame_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (idle_en && $urandom_range(0, 3) == 0) begin
                frame_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 17) - 1) @(negedge i_clk);
            end else begin
                frame_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 24) - 1) @(negedge i_clk);
            end
        end
    end

    // body byte with escaping, sometimes with a spare mark or a pass-through escape
    function automatic void put_body(input logic [BYTE_W-1:0] v);
        if (v == HEAD_BYTE || v == ESC_BYTE) begin
            if ($urandom_range(0, 7) == 0) link_bytes.push_back(ESC_BYTE);
            link_bytes.push_back(ESC_BYTE);
            link_bytes.push_back((v == HEAD_BYTE) ? ESC_HEAD : ESC_ESC);
        end else if (v != ESC_HEAD && v != ESC_ESC && $urandom_range(0, 11) == 0) begin
            link_bytes.push_back(ESC_BYTE);
            link_bytes.push_back(v);
        end else begin
            link_bytes.push_back(v);
        end
    endfunction

    // whole frame with random payload; a bad frame gets a corrupted check byte
    function automatic void put_frame(input logic [15:0] cmd, input logic [15:0] len,
                                      input int n_pay, input bit bad);
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] b;
        sum = HEAD_BYTE ^ cmd[15:8] ^ cmd[7:0] ^ len[15:8] ^ len[7:0];
        link_bytes.push_back(HEAD_BYTE);
        put_body(cmd[15:8]);
        put_body(cmd[7:0]);
        put_body(len[15:8]);
        put_body(len[7:0]);
        for (int i = 0; i < n_pay; i++) begin
            case ($urandom_range(0, 7))
                0:       b = HEAD_BYTE;
                1:       b = ESC_BYTE;
                2:       b = ($urandom_range(0, 1) != 0) ? ESC_HEAD : ESC_ESC;
                default: b = 8'($urandom_range(0, 255));
            endcase
            put_body(b);
            sum ^= b;
        end
        if (bad) sum ^= 8'($urandom_range(1, 255));
        put_body(sum);
    endfunction

    // one byte transaction, with a random gap ahead of it
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            rx_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge i_clk);
        while (!rx_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_link(input bit counted);
        if (counted) frame_bytes += link_bytes.size();
        while (link_bytes.size() != 0) begin
            total_bytes++;
            send_byte(link_bytes.pop_front());
        end
    endtask

    // mostly well-formed frames, the rest noise and cut-off frames
    task automatic random_traffic(input int n_bytes);
        int          start;
        int          r;
        logic [15:0] cmd;
        logic [15:0] len;
        start = frame_bytes;
        while (frame_bytes - start < n_bytes) begin
            if ($urandom_range(0, 9) < 2) begin
                if ($urandom_range(0, 1) != 0) link_bytes.push_back(HEAD_BYTE);
                repeat ($urandom_range(1, 5)) link_bytes.push_back(8'($urandom_range(0, 255)));
                send_link(1'b0);
            end else begin
                case ($urandom_range(0, 7))
                    0:       cmd = 16'h0000;
                    1:       cmd = 16'hFFFF;
                    default: cmd = 16'($urandom);
                endcase
                r = $urandom_range(0, 19);
                if (r < 2 || (cur_limit == 0 && r < 18)) begin
                    len = '0;
                end else if (r < 15) begin
                    len = 16'($urandom_range(1, (cur_limit < 8) ? cur_limit : 8));
                end else if (r < 18) begin
                    len = 16'($urandom_range(1, cur_limit));
                end else if (r == 18) begin
                    len = 16'(cur_limit + $urandom_range(1, 3));
                end else begin
                    len = {8'($urandom_range(1, 255)), 8'($urandom_range(0, 255))};
                end
                put_frame(cmd, len, (int'(len) > cur_limit) ? 0 : int'(len),
                          $urandom_range(0, 9) == 0);
                send_link(1'b1);
            end
        end
    endtask

    // wait until every expected result is out and the parser has settled
    task automatic drain();
        rx_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_max_length(input logic [LEN_W-1:0] v);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.max_length <= v;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        cur_limit = (int'(v) > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(v);
        settings_used++;
    endtask

    // main sequence
    initial begin
        sb                = new();
        i_rst_n           = 1'b0;
        rx_ch.valid       = 1'b0;
        rx_ch.rx_byte     = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.max_length = '0;
        idle_en           = 1'b1;
        hold_req          = 1'b0;
        cur_limit         = MAX_PAYLOAD;
        frame_bytes       = 0;
        total_bytes       = 0;
        settings_used     = 1;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: idle bytes, head restart, empty frame with a double mark on
        // its check, escaped payload with a pass-through escape, oversized length
        link_bytes = {8'h55, ESC_BYTE,
                      HEAD_BYTE, 8'h12,
                      HEAD_BYTE, 8'hFF, 8'hFF, 8'h00, 8'h00, ESC_BYTE, ESC_BYTE, ESC_HEAD,
                      HEAD_BYTE, ESC_BYTE, ESC_ESC, 8'h00, 8'h00, 8'h02,
                      ESC_BYTE, ESC_HEAD, ESC_BYTE, 8'h33, 8'h9A,
                      HEAD_BYTE, 8'h00, 8'h01, 8'h01, 8'h00};
        send_link(1'b1);

        random_traffic(30);

        // long output hold-off while full frames keep coming
        hold_req = 1'b1;
        repeat (2) begin
            put_frame(16'($urandom), 16'd20, 20, 1'b0);
            send_link(1'b1);
        end
        random_traffic(20);

        // smallest limit: only empty frames get through
        drain();
        write_max_length('0);
        random_traffic(20);

        // all ones acts as the store size: longest frame passes, one more is dropped
        drain();
        write_max_length('1);
        put_frame(16'($urandom), 16'(MAX_PAYLOAD), MAX_PAYLOAD, 1'b0);
        put_frame(16'($urandom), 16'(MAX_PAYLOAD + 1), 0, 1'b0);
        send_link(1'b1);
        random_traffic(40);

        drain();
        write_max_length(LEN_W'($urandom_range(1, MAX_PAYLOAD - 1)));
        random_traffic(40);

        // back to the reset value, no idling on either side
        drain();
        write_max_length(MAX_LENGTH_RST);
        idle_en = 1'b0;
        random_traffic(40);

        drain();
        repeat (20) @(negedge i_clk);

        $display("covered %0d link bytes (%0d in frames) over %0d max_length settings",
                 total_bytes, frame_bytes, settings_used);
        $display("%0d good frames, %0d results checked, %0d mismatches",
                 sb.good_frames, sb.results_seen, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/efd_pkg.sv
rtl/efd_ifs.sv
rtl/efd_ctrl.sv
rtl/efd_dp.sv
rtl/escaped_frame_deframer.sv
rtl/efd_checker.sv
tb/escaped_frame_deframer_test.sv
